>>> rtl/arfe_pkg.sv
// Shared types and constants of the alpha rectangle fill engine.
package arfe_pkg;

    // Default frame store geometry in pixels.
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    // Field widths of the command, result and register beats.
    localparam int COORD_W   = 13;
    localparam int PIX_W     = 32;
    localparam int ALPHA_W   = 8;
    localparam int CNT_W     = 13;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    // Pixel count saturation value.
    localparam logic [CNT_W-1:0] CNT_MAX = 13'h1FFF;

    // Opacity codes with a meaning of their own.
    localparam logic [ALPHA_W-1:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // Command codes.
    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 1'b1;

    // Source color and opacity of the draw in progress.
    typedef struct packed {
        logic [PIX_W-1:0]   color;
        logic [ALPHA_W-1:0] alpha;
    } t_blend_cfg;

endpackage

>>> rtl/arfe_blend.sv
// Registered pixel blend unit: destination read data in, write beat out.
module arfe_blend #(
    parameter int AW = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  arfe_pkg::t_blend_cfg       i_cfg,
    input  logic                       i_valid,
    input  logic [AW-1:0]              i_addr,
    input  logic [arfe_pkg::PIX_W-1:0] i_dst,
    output logic                       o_wr_valid,
    output logic [AW-1:0]              o_wr_addr,
    output logic [arfe_pkg::PIX_W-1:0] o_wr_data
);

    logic                        r_valid;
    logic [AW-1:0]               r_addr;
    logic [15:0]                 r_sa   [3];
    logic [15:0]                 r_prod [3];
    logic [arfe_pkg::ALPHA_W-1:0] w_inv;
    logic [16:0]                 w_sum  [3];
    logic [16:0]                 w_fix  [3];
    logic [7:0]                  w_q    [3];

    assign w_inv = arfe_pkg::ALPHA_OPAQUE - i_cfg.alpha;

    // Source term is fixed for a whole draw; destination term is formed per pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_addr <= i_addr;
        for (int c = 0; c < 3; c++) begin
            r_sa[c]   <= 16'(i_cfg.color[c*8 +: 8]) * 16'(i_cfg.alpha);
            r_prod[c] <= 16'(i_dst[c*8 +: 8]) * 16'(w_inv);
        end
    end

    // Truncating divide by 255: (v + 1 + (v >> 8)) >> 8 is exact below 65535.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_sum[c] = 17'(r_sa[c]) + 17'(r_prod[c]);
            w_fix[c] = w_sum[c] + 17'd1 + (w_sum[c] >> 8);
            w_q[c]   = w_fix[c][15:8];
        end
    end

    // A fully opaque draw writes the whole color word, top byte included.
    assign o_wr_valid = r_valid;
    assign o_wr_addr  = r_addr;
    assign o_wr_data  = (i_cfg.alpha == arfe_pkg::ALPHA_OPAQUE) ? i_cfg.color
                                                                : {8'h00, w_q[2], w_q[1], w_q[0]};

endmodule

>>> rtl/alpha_rect_fill_engine.sv
// Top level of the alpha rectangle fill engine: sequencer, frame store and clipping.
//
// The engine owns a frame store of MAX_WIDTH*MAX_HEIGHT 32-bit pixels with a row
// stride of MAX_WIDTH. After reset it clears the store one pixel per cycle with
// busy high. A command is taken when start is high and busy is low; busy then
// stays high until the single result beat is shown on o_done for one cycle, and
// the receiver cannot stall it. An in-range read passes a range check, a wait for
// the registered store read and a data state before its result beat; an
// out-of-range read gives its result beat from the range check. A draw clips the
// origin, clips the far edge and sets up, then scans the clipped pixels and drains
// the pipeline; the single-port-write store does one read-modify-write per cycle
// through the blend unit, and an empty or fully transparent draw ends at setup.
// Configuration writes are taken at any time but are meant for idle periods.
module alpha_rect_fill_engine #(
    parameter int MAX_WIDTH  = arfe_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = arfe_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_cfg_we,
    input  logic [arfe_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [arfe_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 i_command,
    input  logic signed [arfe_pkg::COORD_W-1:0]  i_x_pos,
    input  logic signed [arfe_pkg::COORD_W-1:0]  i_y_pos,
    input  logic signed [arfe_pkg::COORD_W-1:0]  i_rect_width,
    input  logic signed [arfe_pkg::COORD_W-1:0]  i_rect_height,
    input  logic [arfe_pkg::PIX_W-1:0]           i_color,
    input  logic [arfe_pkg::ALPHA_W-1:0]         i_opacity,
    output logic                                 o_done,
    output logic [arfe_pkg::PIX_W-1:0]           o_pixel_value,
    output logic [arfe_pkg::CNT_W-1:0]           o_pixels_written,
    output logic                                 o_out_of_range
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = $clog2(MAX_WIDTH + 1);
    localparam int YW    = $clog2(MAX_HEIGHT + 1);
    localparam int RWW   = (XW > arfe_pkg::CFG_W) ? XW : arfe_pkg::CFG_W;
    localparam int RHW   = (YW > arfe_pkg::CFG_W) ? YW : arfe_pkg::CFG_W;

    typedef logic signed [arfe_pkg::COORD_W+1:0] t_sc;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CLIP1,
        S_CLIP2,
        S_SETUP,
        S_SCAN,
        S_DRAIN,
        S_RCHK,
        S_RWAIT,
        S_RDATA
    } t_state;

    t_state r_state, n_state;

    // Latched command fields.
    logic signed [arfe_pkg::COORD_W-1:0] r_x, n_x, r_y, n_y;
    logic signed [arfe_pkg::COORD_W-1:0] r_w_in, n_w_in, r_h_in, n_h_in;
    logic [arfe_pkg::PIX_W-1:0]          r_color, n_color;
    logic [arfe_pkg::ALPHA_W-1:0]        r_alpha, n_alpha;

    // Clipped rectangle and scan control.
    t_sc                        r_cx, n_cx, r_cy, n_cy, r_cw, n_cw, r_ch, n_ch;
    logic [XW-1:0]              r_wid, n_wid, r_col, n_col;
    logic [YW-1:0]              r_hgt, n_hgt, r_row, n_row;
    logic [AW-1:0]              r_skip, n_skip, r_addr, n_addr;
    logic [arfe_pkg::CNT_W-1:0] r_count, n_count;

    // Read stage of the pixel pipeline.
    logic                       r_v1, n_v1;
    logic [AW-1:0]              r_a1, n_a1;
    logic [arfe_pkg::PIX_W-1:0] r_rd_data;

    // Result beat.
    logic                       r_done, n_done;
    logic [arfe_pkg::PIX_W-1:0] r_pix, n_pix;
    logic [arfe_pkg::CNT_W-1:0] r_cnt_out, n_cnt_out;
    logic                       r_oor, n_oor;

    // Active frame size registers.
    logic [RWW-1:0]             r_act_w;
    logic [RHW-1:0]             r_act_h;

    logic [arfe_pkg::PIX_W-1:0] mem [DEPTH];

    logic                       w_accept;
    logic [XW-1:0]              w_eff_w;
    logic [YW-1:0]              w_eff_h;
    t_sc                        w_fw_s, w_fh_s;
    t_sc                        w_sx, w_sy, w_sw, w_sh;
    logic                       w_last_col, w_last_row;
    logic                       w_oor;
    logic                       w_empty;
    logic                       w_mem_we;
    logic [AW-1:0]              w_mem_waddr;
    logic [arfe_pkg::PIX_W-1:0] w_mem_wdata;
    arfe_pkg::t_blend_cfg       w_blend_cfg;
    logic                       w_wr_valid;
    logic [AW-1:0]              w_wr_addr;
    logic [arfe_pkg::PIX_W-1:0] w_wr_data;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // Register values above the store size act as the store size.
    assign w_eff_w = (r_act_w > RWW'(MAX_WIDTH))  ? XW'(MAX_WIDTH)  : r_act_w[XW-1:0];
    assign w_eff_h = (r_act_h > RHW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : r_act_h[YW-1:0];
    assign w_fw_s  = t_sc'(w_eff_w);
    assign w_fh_s  = t_sc'(w_eff_h);

    assign w_sx = t_sc'(r_x);
    assign w_sy = t_sc'(r_y);
    assign w_sw = t_sc'(r_w_in);
    assign w_sh = t_sc'(r_h_in);

    assign w_last_col = (r_col == r_wid - XW'(1));
    assign w_last_row = (r_row == r_hgt - YW'(1));
    assign w_oor      = (w_sx < 0) || (w_sy < 0) || (w_sx >= w_fw_s) || (w_sy >= w_fh_s);
    assign w_empty    = (r_alpha == arfe_pkg::ALPHA_CLEAR) || (r_cw <= 0) || (r_ch <= 0);

    assign w_blend_cfg.color = r_color;
    assign w_blend_cfg.alpha = r_alpha;

    arfe_blend #(
        .AW (AW)
    ) u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_blend_cfg),
        .i_valid    (r_v1),
        .i_addr     (r_a1),
        .i_dst      (r_rd_data),
        .o_wr_valid (w_wr_valid),
        .o_wr_addr  (w_wr_addr),
        .o_wr_data  (w_wr_data)
    );

    // Sequencer next state.
    always_comb begin
        n_state   = r_state;
        n_x       = r_x;
        n_y       = r_y;
        n_w_in    = r_w_in;
        n_h_in    = r_h_in;
        n_color   = r_color;
        n_alpha   = r_alpha;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_cw      = r_cw;
        n_ch      = r_ch;
        n_wid     = r_wid;
        n_hgt     = r_hgt;
        n_col     = r_col;
        n_row     = r_row;
        n_skip    = r_skip;
        n_addr    = r_addr;
        n_count   = r_count;
        n_v1      = (r_state == S_SCAN);
        n_a1      = r_addr;
        n_done    = 1'b0;
        n_pix     = r_pix;
        n_cnt_out = r_cnt_out;
        n_oor     = r_oor;

        case (r_state)
            S_CLEAR: begin
                // Clearing pass: one pixel per cycle.
                n_addr = r_addr + AW'(1);
                if (r_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_x     = i_x_pos;
                    n_y     = i_y_pos;
                    n_w_in  = i_rect_width;
                    n_h_in  = i_rect_height;
                    n_color = i_color;
                    n_alpha = i_opacity;
                    n_state = (i_command == arfe_pkg::CMD_READ) ? S_RCHK : S_CLIP1;
                end
            end
            S_CLIP1: begin
                // A negative origin eats into the size.
                n_cx = (w_sx < 0) ? '0 : w_sx;
                n_cw = (w_sx < 0) ? w_sw + w_sx : w_sw;
                n_cy = (w_sy < 0) ? '0 : w_sy;
                n_ch = (w_sy < 0) ? w_sh + w_sy : w_sh;
                n_state = S_CLIP2;
            end
            S_CLIP2: begin
                // The far edge is cut back to the active frame.
                if (r_cx + r_cw > w_fw_s) begin
                    n_cw = w_fw_s - r_cx;
                end
                if (r_cy + r_ch > w_fh_s) begin
                    n_ch = w_fh_s - r_cy;
                end
                n_state = S_SETUP;
            end
            S_SETUP: begin
                if (w_empty) begin
                    n_done    = 1'b1;
                    n_pix     = '0;
                    n_cnt_out = '0;
                    n_oor     = 1'b0;
                    n_state   = S_IDLE;
                end else begin
                    n_wid   = r_cw[XW-1:0];
                    n_hgt   = r_ch[YW-1:0];
                    n_col   = '0;
                    n_row   = '0;
                    n_count = '0;
                    n_addr  = AW'(r_cy[YW-1:0] * MAX_WIDTH) + AW'(r_cx[XW-1:0]);
                    n_skip  = AW'(MAX_WIDTH + 1) - AW'(r_cw[XW-1:0]);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // One pixel address per cycle, row by row.
                n_count = (r_count == arfe_pkg::CNT_MAX) ? r_count
                                                         : r_count + arfe_pkg::CNT_W'(1);
                if (w_last_col) begin
                    n_col  = '0;
                    n_row  = r_row + YW'(1);
                    n_addr = r_addr + r_skip;
                    if (w_last_row) begin
                        n_state = S_DRAIN;
                    end
                end else begin
                    n_col  = r_col + XW'(1);
                    n_addr = r_addr + AW'(1);
                end
            end
            S_DRAIN: begin
                // Wait until the last write beat has reached the store.
                if (!r_v1 && !w_wr_valid) begin
                    n_done    = 1'b1;
                    n_pix     = '0;
                    n_cnt_out = r_count;
                    n_oor     = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            S_RCHK: begin
                if (w_oor) begin
                    n_done    = 1'b1;
                    n_pix     = '0;
                    n_cnt_out = '0;
                    n_oor     = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_addr  = AW'(r_y[YW-1:0] * MAX_WIDTH) + AW'(r_x[XW-1:0]);
                    n_state = S_RWAIT;
                end
            end
            S_RWAIT: begin
                n_state = S_RDATA;
            end
            S_RDATA: begin
                n_done    = 1'b1;
                n_pix     = r_rd_data;
                n_cnt_out = '0;
                n_oor     = 1'b0;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer state and registered result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_v1    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_v1    <= n_v1;
            r_done  <= n_done;
        end
        r_x       <= n_x;
        r_y       <= n_y;
        r_w_in    <= n_w_in;
        r_h_in    <= n_h_in;
        r_color   <= n_color;
        r_alpha   <= n_alpha;
        r_cx      <= n_cx;
        r_cy      <= n_cy;
        r_cw      <= n_cw;
        r_ch      <= n_ch;
        r_wid     <= n_wid;
        r_hgt     <= n_hgt;
        r_col     <= n_col;
        r_row     <= n_row;
        r_skip    <= n_skip;
        r_count   <= n_count;
        r_a1      <= n_a1;
        r_pix     <= n_pix;
        r_cnt_out <= n_cnt_out;
        r_oor     <= n_oor;
    end

    // Active frame size registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_w <= RWW'(MAX_WIDTH);
            r_act_h <= RHW'(MAX_HEIGHT);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                arfe_pkg::REG_ACTIVE_WIDTH: begin
                    r_act_w <= RWW'(i_cfg_data);
                end
                arfe_pkg::REG_ACTIVE_HEIGHT: begin
                    r_act_h <= RHW'(i_cfg_data);
                end
                default: begin
                    r_act_w <= r_act_w;
                end
            endcase
        end
    end

    // Frame store: the clearing pass or the blend unit writes, the sequencer address reads.
    assign w_mem_we    = (r_state == S_CLEAR) || w_wr_valid;
    assign w_mem_waddr = (r_state == S_CLEAR) ? r_addr : w_wr_addr;
    assign w_mem_wdata = (r_state == S_CLEAR) ? '0 : w_wr_data;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_rd_data <= mem[r_addr];
    end

    assign o_done           = r_done;
    assign o_pixel_value    = r_pix;
    assign o_pixels_written = r_cnt_out;
    assign o_out_of_range   = r_oor;

`ifndef SYNTHESIS
    // A result beat always hands control back to the idle state.
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result beat outside idle");

    // Blend write beats only come out of a draw in progress.
    a_write_in_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_valid |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("blend write outside a draw");

    // The scan never steps outside the clipped rectangle.
    a_scan_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_col < r_wid && r_row < r_hgt))
        else $error("scan position outside rectangle");

    // An out-of-range read reports neither data nor pixels.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_oor) |-> (r_pix == '0 && r_cnt_out == '0))
        else $error("out-of-range read with nonzero payload");

    // An accepted command makes the engine busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("engine not busy after accepting a command");
`endif

endmodule

>>> sim/arfe_fill_checker.sv
// Checker of the alpha rectangle fill engine: shadow frame store, result prediction and compare.
`timescale 1ns / 1ps

module arfe_fill_checker #(
    parameter int MAX_WIDTH  = arfe_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = arfe_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic                                 i_cfg_we,
    input  logic [arfe_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [arfe_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 i_command,
    input  logic signed [arfe_pkg::COORD_W-1:0]  i_x_pos,
    input  logic signed [arfe_pkg::COORD_W-1:0]  i_y_pos,
    input  logic signed [arfe_pkg::COORD_W-1:0]  i_rect_width,
    input  logic signed [arfe_pkg::COORD_W-1:0]  i_rect_height,
    input  logic [arfe_pkg::PIX_W-1:0]           i_color,
    input  logic [arfe_pkg::ALPHA_W-1:0]         i_opacity,
    input  logic                                 o_done,
    input  logic [arfe_pkg::PIX_W-1:0]           o_pixel_value,
    input  logic [arfe_pkg::CNT_W-1:0]           o_pixels_written,
    input  logic                                 o_out_of_range,
    output int                                   o_fail_count,
    output int                                   o_pending
);

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    typedef struct packed {
        logic [arfe_pkg::PIX_W-1:0] pixel;
        logic [arfe_pkg::CNT_W-1:0] count;
        logic                       oor;
    } t_fill_result;

    // Shadow copy of the frame store and of the two size registers.
    logic [arfe_pkg::PIX_W-1:0] shadow_frame [STORE_DEPTH];
    logic [arfe_pkg::CFG_W-1:0] shadow_width;
    logic [arfe_pkg::CFG_W-1:0] shadow_height;

    // Result beats predicted for accepted commands, oldest first.
    t_fill_result predicted_results [$];
    int fail_count = 0;

    assign o_fail_count = fail_count;

    // A size register above the store geometry acts as the store geometry.
    function automatic int clipped_size(logic [arfe_pkg::CFG_W-1:0] reg_val, int max_val);
        return (int'(reg_val) > max_val) ? max_val : int'(reg_val);
    endfunction

    // One color channel blended over the destination, truncating division.
    function automatic logic [7:0] mixed_channel(int unsigned src, int unsigned dst,
                                                 int unsigned alpha);
        int unsigned mixed;
        mixed = (src * alpha + dst * (255 - alpha)) / 255;
        return mixed[7:0];
    endfunction

    // Clips the rectangle, paints the shadow store and returns the pixel count.
    function automatic logic [arfe_pkg::CNT_W-1:0] paint_rect(
        int x, int y, int w, int h,
        logic [arfe_pkg::PIX_W-1:0] color,
        logic [arfe_pkg::ALPHA_W-1:0] alpha);
        int fw;
        int fh;
        int idx;
        int unsigned count;
        logic [arfe_pkg::PIX_W-1:0] dst;
        fw = clipped_size(shadow_width, MAX_WIDTH);
        fh = clipped_size(shadow_height, MAX_HEIGHT);
        if (alpha == arfe_pkg::ALPHA_CLEAR) return '0;
        if (x < 0) begin
            w += x;
            x = 0;
        end
        if (y < 0) begin
            h += y;
            y = 0;
        end
        if (x + w > fw) w = fw - x;
        if (y + h > fh) h = fh - y;
        if (w <= 0 || h <= 0) return '0;
        for (int j = 0; j < h; j++) begin
            for (int i = 0; i < w; i++) begin
                idx = (y + j) * MAX_WIDTH + (x + i);
                if (idx < STORE_DEPTH) begin
                    if (alpha == arfe_pkg::ALPHA_OPAQUE) begin
                        shadow_frame[idx] = color;
                    end else begin
                        dst = shadow_frame[idx];
                        shadow_frame[idx] = {8'h00,
                            mixed_channel(color[23:16], dst[23:16], alpha),
                            mixed_channel(color[15:8], dst[15:8], alpha),
                            mixed_channel(color[7:0], dst[7:0], alpha)};
                    end
                end
            end
        end
        count = w * h;
        return (count > arfe_pkg::CNT_MAX) ? arfe_pkg::CNT_MAX : count[arfe_pkg::CNT_W-1:0];
    endfunction

    // Expected result beat of one command; a draw also updates the shadow store.
    function automatic t_fill_result predict_fill_result(
        logic cmd, int x, int y, int w, int h,
        logic [arfe_pkg::PIX_W-1:0] color,
        logic [arfe_pkg::ALPHA_W-1:0] alpha);
        t_fill_result res;
        res = '0;
        if (cmd == arfe_pkg::CMD_DRAW) begin
            res.count = paint_rect(x, y, w, h, color, alpha);
        end else if (x < 0 || y < 0 || x >= clipped_size(shadow_width, MAX_WIDTH) ||
                     y >= clipped_size(shadow_height, MAX_HEIGHT)) begin
            res.oor = 1'b1;
        end else if (y * MAX_WIDTH + x < STORE_DEPTH) begin
            res.pixel = shadow_frame[y * MAX_WIDTH + x];
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [arfe_pkg::PIX_W-1:0] want,
                                   logic [arfe_pkg::PIX_W-1:0] got);
        fail_count++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
    endtask

    // Result beats are compared first, then register writes and command beats are taken.
    always @(posedge i_clk) begin
        t_fill_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < STORE_DEPTH; k++) shadow_frame[k] = '0;
            shadow_width  = arfe_pkg::CFG_W'(MAX_WIDTH);
            shadow_height = arfe_pkg::CFG_W'(MAX_HEIGHT);
            predicted_results.delete();
        end else begin
            if (o_done) begin
                if (predicted_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat with nothing expected: expected none, %s",
                             $time, "actual beat below");
                    $display("%0t: actual pixel %h count %0d oor %b",
                             $time, o_pixel_value, o_pixels_written, o_out_of_range);
                end else begin
                    want = predicted_results.pop_front();
                    if (o_pixel_value !== want.pixel)
                        report_mismatch("pixel_value", want.pixel, o_pixel_value);
                    if (o_pixels_written !== want.count)
                        report_mismatch("pixels_written", arfe_pkg::PIX_W'(want.count),
                                        arfe_pkg::PIX_W'(o_pixels_written));
                    if (o_out_of_range !== want.oor)
                        report_mismatch("out_of_range", arfe_pkg::PIX_W'(want.oor),
                                        arfe_pkg::PIX_W'(o_out_of_range));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    arfe_pkg::REG_ACTIVE_WIDTH: begin
                        shadow_width = i_cfg_data;
                    end
                    arfe_pkg::REG_ACTIVE_HEIGHT: begin
                        shadow_height = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (start && !busy)
                predicted_results.push_back(predict_fill_result(i_command, i_x_pos, i_y_pos,
                    i_rect_width, i_rect_height, i_color, i_opacity));
        end
        o_pending <= predicted_results.size();
    end

endmodule

>>> sim/tb_alpha_rect_fill_engine.sv
// Testbench top of the alpha rectangle fill engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_alpha_rect_fill_engine;

    localparam int MAX_W     = arfe_pkg::DEF_MAX_WIDTH;
    localparam int MAX_H     = arfe_pkg::DEF_MAX_HEIGHT;
    localparam int CLK_HALF  = 6;
    localparam int MAX_GAP   = 18;

    typedef struct {
        logic                                command;
        logic signed [arfe_pkg::COORD_W-1:0] x;
        logic signed [arfe_pkg::COORD_W-1:0] y;
        logic signed [arfe_pkg::COORD_W-1:0] w;
        logic signed [arfe_pkg::COORD_W-1:0] h;
        logic [arfe_pkg::PIX_W-1:0]          color;
        logic [arfe_pkg::ALPHA_W-1:0]        alpha;
    } t_fill_cmd;

    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                start         = 1'b0;
    logic                                i_cfg_we      = 1'b0;
    logic [arfe_pkg::CFG_IDX_W-1:0]      i_cfg_index   = arfe_pkg::REG_ACTIVE_WIDTH;
    logic [arfe_pkg::CFG_W-1:0]          i_cfg_data    = '0;
    logic                                i_command     = arfe_pkg::CMD_DRAW;
    logic signed [arfe_pkg::COORD_W-1:0] i_x_pos       = '0;
    logic signed [arfe_pkg::COORD_W-1:0] i_y_pos       = '0;
    logic signed [arfe_pkg::COORD_W-1:0] i_rect_width  = '0;
    logic signed [arfe_pkg::COORD_W-1:0] i_rect_height = '0;
    logic [arfe_pkg::PIX_W-1:0]          i_color       = '0;
    logic [arfe_pkg::ALPHA_W-1:0]        i_opacity     = '0;
    logic                                busy;
    logic                                o_done;
    logic [arfe_pkg::PIX_W-1:0]          o_pixel_value;
    logic [arfe_pkg::CNT_W-1:0]          o_pixels_written;
    logic                                o_out_of_range;
    int                                  fail_count;
    int                                  pending;

    // Visible size in force, used only to aim the random commands.
    int  vis_w   = MAX_W;
    int  vis_h   = MAX_H;
    bit  no_gaps = 1'b0;

    always #(CLK_HALF) i_clk = ~i_clk;

    alpha_rect_fill_engine #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_command        (i_command),
        .i_x_pos          (i_x_pos),
        .i_y_pos          (i_y_pos),
        .i_rect_width     (i_rect_width),
        .i_rect_height    (i_rect_height),
        .i_color          (i_color),
        .i_opacity        (i_opacity),
        .o_done           (o_done),
        .o_pixel_value    (o_pixel_value),
        .o_pixels_written (o_pixels_written),
        .o_out_of_range   (o_out_of_range)
    );

    arfe_fill_checker #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_fill_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_command        (i_command),
        .i_x_pos          (i_x_pos),
        .i_y_pos          (i_y_pos),
        .i_rect_width     (i_rect_width),
        .i_rect_height    (i_rect_height),
        .i_color          (i_color),
        .i_opacity        (i_opacity),
        .o_done           (o_done),
        .o_pixel_value    (o_pixel_value),
        .o_pixels_written (o_pixels_written),
        .o_out_of_range   (o_out_of_range),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    function automatic t_fill_cmd draw_cmd(int x, int y, int w, int h,
                                           logic [arfe_pkg::PIX_W-1:0] color,
                                           logic [arfe_pkg::ALPHA_W-1:0] alpha);
        t_fill_cmd c;
        c.command = arfe_pkg::CMD_DRAW;
        c.x       = arfe_pkg::COORD_W'(x);
        c.y       = arfe_pkg::COORD_W'(y);
        c.w       = arfe_pkg::COORD_W'(w);
        c.h       = arfe_pkg::COORD_W'(h);
        c.color   = color;
        c.alpha   = alpha;
        return c;
    endfunction

    // The size, color and opacity of a read are ignored, so they carry noise.
    function automatic t_fill_cmd read_cmd(int x, int y);
        t_fill_cmd c;
        c = draw_cmd(x, y, $urandom_range(0, 8191), $urandom_range(0, 8191), $urandom,
                     arfe_pkg::ALPHA_W'($urandom_range(0, 255)));
        c.command = arfe_pkg::CMD_READ;
        return c;
    endfunction

    function automatic logic [arfe_pkg::ALPHA_W-1:0] rand_opacity();
        case ($urandom_range(0, 5))
            0: begin
                return arfe_pkg::ALPHA_CLEAR;
            end
            1, 2: begin
                return arfe_pkg::ALPHA_OPAQUE;
            end
            default: begin
                return arfe_pkg::ALPHA_W'($urandom_range(1, 254));
            end
        endcase
    endfunction

    // Mostly rectangles and reads around the visible frame, some pure noise.
    function automatic t_fill_cmd rand_fill_cmd();
        int pick;
        int shape;
        int x;
        int y;
        int w;
        int h;
        t_fill_cmd c;
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
            c = draw_cmd($urandom_range(0, 8191), $urandom_range(0, 8191),
                         $urandom_range(0, 8191), $urandom_range(0, 8191), $urandom,
                         arfe_pkg::ALPHA_W'($urandom_range(0, 255)));
            c.command = 1'($urandom_range(0, 1));
        end else if (pick < 12) begin
            shape = $urandom_range(0, 15);
            if (shape == 0) begin
                // Full-screen fill, sometimes with a far edge well past the frame.
                x = 0;
                y = 0;
                w = $urandom_range(0, 1) ? vis_w : 4095;
                h = $urandom_range(0, 1) ? vis_h : 4095;
            end else if (shape == 1) begin
                x = int'($urandom_range(0, vis_w + 8)) - 8;
                y = int'($urandom_range(0, vis_h + 8)) - 8;
                w = $urandom_range(16, 72);
                h = $urandom_range(16, 72);
            end else begin
                x = int'($urandom_range(0, vis_w + 8)) - 4;
                y = int'($urandom_range(0, vis_h + 8)) - 4;
                w = int'($urandom_range(0, 10)) - 1;
                h = int'($urandom_range(0, 10)) - 1;
            end
            c = draw_cmd(x, y, w, h, $urandom, rand_opacity());
        end else begin
            c = read_cmd(int'($urandom_range(0, vis_w + 1)) - 1,
                         int'($urandom_range(0, vis_h + 1)) - 1);
        end
        return c;
    endfunction

    function automatic int next_gap();
        return no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Presents one command beat after the given gap; returns at the edge that takes it.
    task automatic issue_command(t_fill_cmd c, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_command     <= c.command;
        i_x_pos       <= c.x;
        i_y_pos       <= c.y;
        i_rect_width  <= c.w;
        i_rect_height <= c.h;
        i_color       <= c.color;
        i_opacity     <= c.alpha;
        start         <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    // Holds off new commands until every predicted result beat has arrived.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_active_size(int w, int h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= arfe_pkg::REG_ACTIVE_WIDTH;
        i_cfg_data  <= arfe_pkg::CFG_W'(w);
        @(posedge i_clk);
        i_cfg_index <= arfe_pkg::REG_ACTIVE_HEIGHT;
        i_cfg_data  <= arfe_pkg::CFG_W'(h);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        vis_w = (w > MAX_W) ? MAX_W : w;
        vis_h = (h > MAX_H) ? MAX_H : h;
    endtask

    // Stimulus: reset, directed commands, then random phases over several frame sizes.
    initial begin
        int n_items;
        int cfg_w;
        int cfg_h;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        // The engine clears its store after reset with busy high.
        while (busy !== 1'b0) @(posedge i_clk);
        write_active_size(MAX_W, MAX_H);

        // Reads of the cleared store, inside and outside the frame.
        issue_command(read_cmd(0, 0), next_gap());
        issue_command(read_cmd(MAX_W - 1, MAX_H - 1), next_gap());
        issue_command(read_cmd(-1, 0), next_gap());
        issue_command(read_cmd(0, MAX_H), next_gap());
        issue_command(read_cmd(-4096, 4095), next_gap());
        // Full-screen opaque fill, then a single blended pixel.
        issue_command(draw_cmd(0, 0, MAX_W, MAX_H, 32'hFFFF_FFFF, arfe_pkg::ALPHA_OPAQUE),
                      next_gap());
        issue_command(read_cmd(10, 10), next_gap());
        issue_command(draw_cmd(5, 7, 1, 1, 32'h0012_3456, 8'd128), next_gap());
        issue_command(read_cmd(5, 7), next_gap());
        // Transparent draws write nothing.
        issue_command(draw_cmd(0, 0, MAX_W, MAX_H, 32'hFF00_0000, arfe_pkg::ALPHA_CLEAR),
                      next_gap());
        issue_command(draw_cmd(3, 3, 1, 1, 32'h00AB_CDEF, arfe_pkg::ALPHA_CLEAR), next_gap());
        // Negative origin and far edge clipping with the extreme blend weights.
        issue_command(draw_cmd(-3, 2, 5, 3, 32'h80FF_00FF, 8'd1), next_gap());
        issue_command(read_cmd(0, 2), next_gap());
        issue_command(draw_cmd(60, 61, 10, 10, 32'h0102_0304, 8'd254), next_gap());
        issue_command(read_cmd(MAX_W - 1, MAX_H - 1), next_gap());
        // Empty rectangles: zero and negative sizes, and the coordinate extremes.
        issue_command(draw_cmd(2, 2, 0, 5, 32'h1111_1111, arfe_pkg::ALPHA_OPAQUE), next_gap());
        issue_command(draw_cmd(2, 2, -5, 3, 32'h2222_2222, arfe_pkg::ALPHA_OPAQUE),
                      next_gap());
        issue_command(draw_cmd(-4096, -4096, 4095, 4095, 32'h3333_3333,
                               arfe_pkg::ALPHA_OPAQUE), next_gap());
        issue_command(draw_cmd(4095, 4095, 4095, 4095, 32'h4444_4444,
                               arfe_pkg::ALPHA_OPAQUE), next_gap());
        issue_command(draw_cmd(2, 2, -4096, -4096, 32'h5555_5555, arfe_pkg::ALPHA_OPAQUE),
                      next_gap());
        // Oversized rectangle clipped on all sides down to the whole frame.
        issue_command(draw_cmd(-10, -10, 4095, 4095, 32'h0000_0000, arfe_pkg::ALPHA_OPAQUE),
                      next_gap());
        issue_command(read_cmd(5, 7), next_gap());
        issue_command(read_cmd(MAX_W - 1, 0), next_gap());

        // Random phases; each ends idle so the frame size can change safely.
        for (int phase = 0; phase < 7; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    cfg_w = MAX_W;
                    cfg_h = MAX_H;
                    n_items = 20;
                end
                1: begin
                    cfg_w = 1;
                    cfg_h = 1;
                    n_items = 12;
                end
                2: begin
                    cfg_w = $urandom_range(1, MAX_W);
                    cfg_h = $urandom_range(1, MAX_H);
                    n_items = 18;
                end
                3: begin
                    // Register values beyond the store act as the full store.
                    cfg_w = 127;
                    cfg_h = 100;
                    n_items = 18;
                end
                4: begin
                    // An empty frame: no draw writes and every read is out of range.
                    cfg_w = 0;
                    cfg_h = 0;
                    n_items = 8;
                end
                5: begin
                    cfg_w = $urandom_range(0, 127);
                    cfg_h = $urandom_range(0, 127);
                    n_items = 20;
                end
                default: begin
                    cfg_w = MAX_W;
                    cfg_h = $urandom_range(1, MAX_H);
                    n_items = 18;
                end
            endcase
            write_active_size(cfg_w, cfg_h);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < n_items; n++) begin
                if ($urandom_range(0, 11) == 0) wait_idle();
                issue_command(rand_fill_cmd(), next_gap());
            end
        end

        wait_idle();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** alpha_rect_fill_engine: PASSED **");
        end else begin
            $display("** alpha_rect_fill_engine: FAILED **");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #40_000_000;
        $display("** alpha_rect_fill_engine: FAILED **");
        $finish;
    end

endmodule
